/* hw/rtl/rvfm_pkg.sv */
// ============================================================================
// rvfm_pkg
// Shared types, register indexes and window tables for the rail voltage
// fault monitor.
// ============================================================================
`default_nettype none

package rvfm_pkg;

    // Geometry
    localparam int NUM_RAILS  = 3;
    localparam int DELAY_BITS = 16;
    localparam int CODE_BITS  = 7;
    localparam int MV_BITS    = 12;
    localparam int BULK_BITS  = 16;
    localparam int CFG_DLY_W  = 16;
    localparam int NIB_BITS   = 4;
    localparam int SET_BITS   = 12;   // setpoint, max 1500 + 5 * 127 = 2135
    localparam int PROD_BITS  = 26;   // 4095 * 10000 fits in 26 bits
    localparam int HIGH_BASE_RAIL = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CODE_BITS * NUM_RAILS;

    localparam logic [CFG_IDX_W-1:0] REG_RAIL_CODES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SELECT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_OV_DELAY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_UV_DELAY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IN_GSI_DELAY  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IN_DIS_DELAY  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BULK_OVER     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BULK_UNDER    = 3'd7;

    // Setpoint constants (mV)
    localparam logic [SET_BITS-1:0] BASE_LOW_MV  = 12'd800;
    localparam logic [SET_BITS-1:0] BASE_HIGH_MV = 12'd1500;
    localparam logic [2:0]          STEP_MV      = 3'd5;
    localparam logic [13:0]         SCALE_ONE    = 14'd10000;

    // Window select codes
    localparam logic [1:0] OV_SEL_075     = 2'd0;
    localparam logic [1:0] OV_SEL_100     = 2'd1;
    localparam logic [1:0] OV_SEL_125     = 2'd2;
    localparam logic [1:0] OV_SEL_OFF     = 2'd3;
    localparam logic [1:0] UV_SEL_100     = 2'd0;
    localparam logic [1:0] UV_SEL_125     = 2'd1;
    localparam logic [1:0] UV_SEL_OFF     = 2'd2;
    localparam logic [1:0] UV_SEL_OFF_ALT = 2'd3;

    // Payload words
    typedef struct packed {
        logic [MV_BITS-1:0]   rail_a_mv;
        logic [MV_BITS-1:0]   rail_b_mv;
        logic [MV_BITS-1:0]   rail_c_mv;
        logic [BULK_BITS-1:0] bulk_mv;
    } in_word_t;

    typedef struct packed {
        logic rail_over;
        logic rail_under;
        logic bulk_gsi;
        logic bulk_over;
        logic bulk_under;
    } out_word_t;

    // Status from one rail lane
    typedef struct packed {
        logic ov_fault;
        logic uv_fault;
    } lane_flags_t;

    // Status from the bulk monitor
    typedef struct packed {
        logic gsi;
        logic over;
        logic under;
    } bulk_flags_t;

    // OV window scale (x10000); zero means the window is off
    function automatic logic [13:0] ov_scale(input logic [1:0] sel);
        logic [13:0] s;
        case (sel)
            OV_SEL_075: s = 14'd10075;
            OV_SEL_100: s = 14'd10100;
            OV_SEL_125: s = 14'd10125;
            default:    s = 14'd0;
        endcase
        return s;
    endfunction

    // UV window scale (x10000); zero means the window is off
    function automatic logic [13:0] uv_scale(input logic [1:0] sel);
        logic [13:0] s;
        case (sel)
            UV_SEL_100: s = 14'd9900;
            UV_SEL_125: s = 14'd9875;
            default:    s = 14'd0;
        endcase
        return s;
    endfunction

    // Clamp a configured delay to what the persistence counter can hold
    function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [CFG_DLY_W-1:0] d);
        logic [32:0] cap;
        cap = (33'd1 << DELAY_BITS) - 33'd1;
        if (33'(d) > cap) begin
            return cap[DELAY_BITS-1:0];
        end
        return DELAY_BITS'(d);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rail_voltage_fault_monitor.sv */
// ============================================================================
// rail_voltage_fault_monitor
// Rail OV/UV window monitor with persistence qualification and bulk input
// GSI/OV/UV monitor. One result word per input word.
// ============================================================================
//
//  channel   ports                          payload
//  -------   ----------------------------   -----------------------------
//  input     s_valid / s_ready / s_data     in_word_t  (3 rails + bulk)
//  result    m_valid / m_ready / m_data     out_word_t (5 fault flags)
//  config    cfg_valid / cfg_ready          cfg_index, cfg_data
//
//  One word per clock while m_ready is high; result is valid the next cycle.
//  Rail lanes and bulk monitor work in parallel; the OR-merged lane flags
//  and the bulk flags go into the output register. s_ready is high whenever
//  the output register is empty or being drained, so a stalled m_ready stops
//  input only once the register holds an unclaimed word. Synchronous reset
//  clears qualifier state, output valid and config; bulk over limit to 1s.
//
`default_nettype none

module rail_voltage_fault_monitor
    import rvfm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input words
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire in_word_t               s_data,
    // result words
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output out_word_t                   m_data,
    // configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CODE_BITS*NUM_RAILS-1:0] rail_codes_reg;
    logic [NIB_BITS*NUM_RAILS-1:0]  window_sel_reg;
    logic [CFG_DLY_W-1:0]           ov_delay_reg, uv_delay_reg;
    logic [CFG_DLY_W-1:0]           gsi_delay_reg, dis_delay_reg;
    logic [BULK_BITS-1:0]           bulk_over_reg, bulk_under_reg;

    logic                           step;
    logic [MV_BITS-1:0]             rail_mv [NUM_RAILS];
    lane_flags_t                    lane_flags [NUM_RAILS];
    bulk_flags_t                    bflags;
    logic                           any_ov, any_uv;

    logic                           m_valid_reg, m_valid_next;
    out_word_t                      m_data_reg, m_data_next;

    // Configuration register bank
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_codes_reg <= '0;
            window_sel_reg <= '0;
            ov_delay_reg   <= '0;
            uv_delay_reg   <= '0;
            gsi_delay_reg  <= '0;
            dis_delay_reg  <= '0;
            bulk_over_reg  <= '1;
            bulk_under_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_RAIL_CODES:    rail_codes_reg <= cfg_data[CODE_BITS*NUM_RAILS-1:0];
                REG_WINDOW_SELECT: window_sel_reg <= cfg_data[NIB_BITS*NUM_RAILS-1:0];
                REG_OUT_OV_DELAY:  ov_delay_reg   <= cfg_data[CFG_DLY_W-1:0];
                REG_OUT_UV_DELAY:  uv_delay_reg   <= cfg_data[CFG_DLY_W-1:0];
                REG_IN_GSI_DELAY:  gsi_delay_reg  <= cfg_data[CFG_DLY_W-1:0];
                REG_IN_DIS_DELAY:  dis_delay_reg  <= cfg_data[CFG_DLY_W-1:0];
                REG_BULK_OVER:     bulk_over_reg  <= cfg_data[BULK_BITS-1:0];
                REG_BULK_UNDER:    bulk_under_reg <= cfg_data[BULK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: accept while the output register is free or draining
    assign s_ready = ~m_valid_reg | m_ready;
    assign step    = s_valid & s_ready;

    assign rail_mv[0] = s_data.rail_a_mv;
    assign rail_mv[1] = s_data.rail_b_mv;
    assign rail_mv[2] = s_data.rail_c_mv;

    // Rail lanes
    for (genvar r = 0; r < NUM_RAILS; r++) begin : g_lane
        rvfm_rail_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .step      (step),
            .mv        (rail_mv[r]),
            .code      (rail_codes_reg[CODE_BITS*r +: CODE_BITS]),
            .high_base ((r == HIGH_BASE_RAIL) ? 1'b1 : 1'b0),
            .nib       (window_sel_reg[NIB_BITS*r +: NIB_BITS]),
            .ov_delay  (ov_delay_reg),
            .uv_delay  (uv_delay_reg),
            .flags     (lane_flags[r])
        );
    end

    rvfm_bulk u_bulk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .bulk_mv     (s_data.bulk_mv),
        .over_limit  (bulk_over_reg),
        .under_limit (bulk_under_reg),
        .gsi_delay   (gsi_delay_reg),
        .dis_delay   (dis_delay_reg),
        .uv_delay    (uv_delay_reg),
        .flags       (bflags)
    );

    // Merge lane flags
    always_comb begin
        any_ov = 1'b0;
        any_uv = 1'b0;
        for (int r = 0; r < NUM_RAILS; r++) begin
            any_ov = any_ov | lane_flags[r].ov_fault;
            any_uv = any_uv | lane_flags[r].uv_fault;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg & ~m_ready;
        m_data_next  = m_data_reg;
        if (step) begin
            m_valid_next           = 1'b1;
            m_data_next.rail_over  = any_ov;
            m_data_next.rail_under = any_uv;
            m_data_next.bulk_gsi   = bflags.gsi;
            m_data_next.bulk_over  = bflags.over;
            m_data_next.bulk_under = bflags.under;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

/* hw/rtl/rvfm_persist.sv */
// ============================================================================
// rvfm_persist
// Persistence qualifier: counts words while a condition holds, saturates at
// the delay and then latches a trigger. Loss of the condition clears both.
// ============================================================================
`default_nettype none

module rvfm_persist
    import rvfm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic                  cond,
    input  wire logic [CFG_DLY_W-1:0]  delay,
    output logic                       trig_now
);

    logic [DELAY_BITS-1:0] count_reg, count_next;
    logic                  trig_reg, trig_next;
    logic [DELAY_BITS-1:0] limit;
    logic                  below;

    // Next counter and trigger for the word being accepted
    always_comb begin
        limit = sat_delay(delay);
        below = (count_reg < limit);
        if (cond) begin
            count_next = below ? count_reg + 1'b1 : count_reg;
            trig_next  = trig_reg | ~below;
        end else begin
            count_next = '0;
            trig_next  = 1'b0;
        end
    end

    assign trig_now = trig_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            trig_reg  <= 1'b0;
        end else if (step) begin
            count_reg <= count_next;
            trig_reg  <= trig_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rvfm_rail_lane.sv */
// ============================================================================
// rvfm_rail_lane
// One rail: setpoint from its code, OV/UV window compares and the two
// persistence qualifiers.
// ============================================================================
`default_nettype none

module rvfm_rail_lane
    import rvfm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [MV_BITS-1:0]    mv,
    input  wire logic [CODE_BITS-1:0]  code,
    input  wire logic                  high_base,
    input  wire logic [NIB_BITS-1:0]   nib,
    input  wire logic [CFG_DLY_W-1:0]  ov_delay,
    input  wire logic [CFG_DLY_W-1:0]  uv_delay,
    output lane_flags_t                flags
);

    logic [SET_BITS-1:0]  setpoint;
    logic [13:0]          os, us;
    logic [PROD_BITS-1:0] meas_x, ov_lim, uv_lim;
    logic                 ov, uv, tov, tuv;

    // Setpoint and exact window compares (scaled by 10000)
    always_comb begin
        setpoint = (high_base ? BASE_HIGH_MV : BASE_LOW_MV)
                 + SET_BITS'(code) * SET_BITS'(STEP_MV);
        os       = ov_scale(nib[3:2]);
        us       = uv_scale(nib[1:0]);
        meas_x   = PROD_BITS'(mv) * PROD_BITS'(SCALE_ONE);
        ov_lim   = PROD_BITS'(setpoint) * PROD_BITS'(os);
        uv_lim   = PROD_BITS'(setpoint) * PROD_BITS'(us);
        ov       = (os != '0) && (meas_x > ov_lim);
        uv       = (us != '0) && (meas_x < uv_lim);
    end

    rvfm_persist u_ov (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cond     (ov),
        .delay    (ov_delay),
        .trig_now (tov)
    );

    rvfm_persist u_uv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cond     (uv),
        .delay    (uv_delay),
        .trig_now (tuv)
    );

    assign flags.ov_fault = ov & tov;
    assign flags.uv_fault = uv & tuv;

endmodule

`default_nettype wire

/* hw/rtl/rvfm_bulk.sv */
// ============================================================================
// rvfm_bulk
// Bulk input monitor: limit compares, qualifiers running on the previous
// word's compares, outputs gated by the current compares.
// ============================================================================
`default_nettype none

module rvfm_bulk
    import rvfm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step,
    input  wire logic [BULK_BITS-1:0]  bulk_mv,
    input  wire logic [BULK_BITS-1:0]  over_limit,
    input  wire logic [BULK_BITS-1:0]  under_limit,
    input  wire logic [CFG_DLY_W-1:0]  gsi_delay,
    input  wire logic [CFG_DLY_W-1:0]  dis_delay,
    input  wire logic [CFG_DLY_W-1:0]  uv_delay,
    output bulk_flags_t                flags
);

    logic over_last_reg, under_last_reg;
    logic over_now, under_now;
    logic tgsi, tbov, tbuv;

    assign over_now  = bulk_mv > over_limit;
    assign under_now = bulk_mv < under_limit;

    // Compares of the last accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            over_last_reg  <= 1'b0;
            under_last_reg <= 1'b0;
        end else if (step) begin
            over_last_reg  <= over_now;
            under_last_reg <= under_now;
        end
    end

    rvfm_persist u_gsi (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cond     (over_last_reg),
        .delay    (gsi_delay),
        .trig_now (tgsi)
    );

    rvfm_persist u_bov (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cond     (over_last_reg),
        .delay    (dis_delay),
        .trig_now (tbov)
    );

    rvfm_persist u_buv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .cond     (under_last_reg),
        .delay    (uv_delay),
        .trig_now (tbuv)
    );

    assign flags.gsi   = tgsi & over_now;
    assign flags.over  = tbov & over_now;
    assign flags.under = tbuv & under_now;

endmodule

`default_nettype wire
